// ----- design/line_position_estimator_top_defines.svh -----
// Assertion macros for the line position estimator.
`ifndef LINE_POSITION_ESTIMATOR_TOP_DEFINES_SVH
`define LINE_POSITION_ESTIMATOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// cond must hold at every edge outside reset
`define LPE_ASSERT(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);
// when trig holds, cond must hold at the next edge
`define LPE_ASSERT_NEXT(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cond)) \
        else $error(msg);
`else
`define LPE_ASSERT(label, clk, rstn, cond, msg)
`define LPE_ASSERT_NEXT(label, clk, rstn, trig, cond, msg)
`endif

`endif

// ----- design/lpe_pkg.sv -----
package lpe_pkg;

    parameter int SENSOR_COUNT      = 5;
    parameter int HISTORY_DEPTH_DEF = 7;

    parameter int READING_W       = 10;
    parameter int READING_MAX     = 1000;
    parameter int POS_STEP        = 1000;
    parameter int THRESHOLD_RESET = 100;
    parameter int POS_W           = 13;
    parameter int POSITION_MAX    = 4095;

    // widths of the centroid sums
    parameter int WPROD_MAX = (SENSOR_COUNT - 1) * POS_STEP * READING_MAX;
    parameter int WPROD_W   = $clog2(WPROD_MAX + 1);
    parameter int WSUM_MAX  = (SENSOR_COUNT * (SENSOR_COUNT - 1) / 2) * POS_STEP * READING_MAX;
    parameter int WSUM_W    = $clog2(WSUM_MAX + 1);
    parameter int TOTAL_W   = $clog2(SENSOR_COUNT * READING_MAX + 1);

    typedef logic [READING_W-1:0]    reading_t;
    typedef logic [WSUM_W-1:0]       wsum_t;
    typedef logic [TOTAL_W-1:0]      total_t;
    typedef logic signed [POS_W-1:0] position_t;

    parameter position_t POSITION_LOST = '1;

    typedef struct packed {
        logic load;     // store new reading, update ring sum
        logic mul_en;   // multiply sum by reciprocal
        logic mean_en;  // take mean from product
    } lane_ctl_t;

    typedef struct packed {
        wsum_t  wsum;
        total_t total;
        logic   any_dark;
    } merge_res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- design/lpe_lane.sv -----
module lpe_lane #(
    parameter int HISTORY_DEPTH = lpe_pkg::HISTORY_DEPTH_DEF,
    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lpe_pkg::lane_ctl_t ctl,
    input  logic [SLOT_W-1:0] slot,
    input  lpe_pkg::reading_t reading,
    output lpe_pkg::reading_t mean
);
    import lpe_pkg::*;

    localparam int SUM_W   = $clog2(HISTORY_DEPTH * READING_MAX + 1);
    localparam int DIV_L   = $clog2(HISTORY_DEPTH);
    localparam int SHIFT   = SUM_W + DIV_L;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // rounded-up reciprocal: exact floor division for every sum below 2**SUM_W
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;

    reading_t            ring_reg [HISTORY_DEPTH];
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [PROD_W-1:0]   prod_reg;
    reading_t            mean_reg;
    reading_t            sat;

    always_comb begin
        sat      = (reading > reading_t'(READING_MAX)) ? reading_t'(READING_MAX) : reading;
        sum_next = sum_reg - SUM_W'(ring_reg[slot]) + SUM_W'(sat);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (ctl.load) begin
            ring_reg[slot] <= sat;
            sum_reg        <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP_W'(RECIP));
        end
        if (ctl.mean_en) begin
            mean_reg <= prod_reg[SHIFT +: READING_W];
        end
    end

    assign mean = mean_reg;

endmodule

// ----- design/lpe_merge.sv -----
module lpe_merge (
    input  logic                 aclk,
    input  logic                 en,
    input  lpe_pkg::reading_t    means [lpe_pkg::SENSOR_COUNT],
    input  lpe_pkg::reading_t    threshold,
    output lpe_pkg::merge_res_t  res
);
    import lpe_pkg::*;

    merge_res_t res_reg;
    merge_res_t res_next;

    // dark lanes add their weighted mean and their mean
    always_comb begin
        res_next = '0;
        for (int s = 0; s < SENSOR_COUNT; s++) begin
            if (means[s] > threshold) begin
                res_next.any_dark = 1'b1;
                res_next.wsum     = res_next.wsum +
                    WSUM_W'(WPROD_W'(means[s]) * WPROD_W'(s * POS_STEP));
                res_next.total    = res_next.total + TOTAL_W'(means[s]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- design/lpe_div.sv -----
module lpe_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  lpe_pkg::wsum_t     dividend,
    input  lpe_pkg::total_t    divisor,
    output lpe_pkg::wsum_t     quotient,
    output lpe_pkg::div_stat_t stat
);
    import lpe_pkg::*;

    localparam int CNT_W = $clog2(WSUM_W + 1);

    wsum_t              quo_reg;
    total_t             rem_reg;
    total_t             dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    div_stat_t          stat_reg;
    logic [TOTAL_W:0]   rem_shift;
    logic               take;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_shift = {rem_reg, quo_reg[WSUM_W-1]};
        take      = rem_shift >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stat_reg <= '0;
            cnt_reg  <= '0;
        end else if (start) begin
            quo_reg       <= dividend;
            rem_reg       <= '0;
            dvs_reg       <= divisor;
            cnt_reg       <= CNT_W'(WSUM_W);
            stat_reg.busy <= 1'b1;
            stat_reg.done <= 1'b0;
        end else if (stat_reg.busy) begin
            quo_reg <= {quo_reg[WSUM_W-2:0], take};
            rem_reg <= take ? TOTAL_W'(rem_shift - {1'b0, dvs_reg}) : rem_shift[TOTAL_W-1:0];
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                stat_reg.busy <= 1'b0;
                stat_reg.done <= 1'b1;
            end
        end else begin
            stat_reg.done <= 1'b0;
        end
    end

    assign quotient = quo_reg;
    assign stat     = stat_reg;

endmodule

// ----- design/line_position_estimator_top.sv -----
// Channel    | Ports                              | Direction | Moves
// -----------+------------------------------------+-----------+---------------------------
// sensor in  | s_valid, s_ready, s_sensor_0..4    | in        | one request of 5 readings
// result out | m_valid, m_ready, m_mean_0..4,     | out       | one result per request
//            | m_line_position, m_line_lost,      |           |
//            | m_line_recovered                   |           |
// config     | cfg_we, cfg_wdata                  | in        | dark threshold write
//
// A request passes from accept to result through the lanes, which update their rings
// and then their means, the merge, and the shared restoring divider, which works
// through the weighted sum one bit at a time.
// Reset is synchronous, active low; it clears the history rings, ring sums, slot,
// lost flag and sets the threshold to 100. No clearing pass is needed.
// A finished result waits in the output register while the next request is taken;
// only when a second result is ready before the first is taken does the block stall.
`include "line_position_estimator_top_defines.svh"

module line_position_estimator_top #(
    parameter int HISTORY_DEPTH = lpe_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_we,
    input  lpe_pkg::reading_t   cfg_wdata,

    input  logic                s_valid,
    output logic                s_ready,
    input  lpe_pkg::reading_t   s_sensor_0,
    input  lpe_pkg::reading_t   s_sensor_1,
    input  lpe_pkg::reading_t   s_sensor_2,
    input  lpe_pkg::reading_t   s_sensor_3,
    input  lpe_pkg::reading_t   s_sensor_4,

    output logic                m_valid,
    input  logic                m_ready,
    output lpe_pkg::reading_t   m_mean_0,
    output lpe_pkg::reading_t   m_mean_1,
    output lpe_pkg::reading_t   m_mean_2,
    output lpe_pkg::reading_t   m_mean_3,
    output lpe_pkg::reading_t   m_mean_4,
    output lpe_pkg::position_t  m_line_position,
    output logic                m_line_lost,
    output logic                m_line_recovered
);
    import lpe_pkg::*;

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,    // wait for a request
        ST_MUL,     // lanes: sum times reciprocal
        ST_MEAN,    // lanes: take mean
        ST_MERGE,   // threshold and weighted sums
        ST_DIVGO,   // launch the divider
        ST_DIV,     // wait for the quotient
        ST_OUT      // hand the result to the output register
    } state_t;

    state_t              state_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                was_lost_reg;
    reading_t            thr_reg;

    logic                m_valid_reg;
    reading_t            m_mean_reg [SENSOR_COUNT];
    position_t           m_pos_reg;
    logic                m_lost_reg;
    logic                m_recov_reg;

    reading_t            readings [SENSOR_COUNT];
    reading_t            means    [SENSOR_COUNT];
    lane_ctl_t           lane_ctl;
    merge_res_t          merge_res;
    wsum_t               quot;
    div_stat_t           div_stat;

    logic                accept;
    logic                lost;
    position_t           pos;
    logic                out_free;

    assign readings[0] = s_sensor_0;
    assign readings[1] = s_sensor_1;
    assign readings[2] = s_sensor_2;
    assign readings[3] = s_sensor_3;
    assign readings[4] = s_sensor_4;

    // keep the input closed while reset is held
    assign s_ready = aresetn && (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign lane_ctl.load    = accept;
    assign lane_ctl.mul_en  = (state_reg == ST_MUL);
    assign lane_ctl.mean_en = (state_reg == ST_MEAN);

    // One lane per sensor: ring, running sum and mean.
    for (genvar s = 0; s < SENSOR_COUNT; s++) begin : g_lane
        lpe_lane #(
            .HISTORY_DEPTH (HISTORY_DEPTH)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl),
            .slot    (slot_reg),
            .reading (readings[s]),
            .mean    (means[s])
        );
    end

    lpe_merge u_merge (
        .aclk      (aclk),
        .en        (state_reg == ST_MERGE),
        .means     (means),
        .threshold (thr_reg),
        .res       (merge_res)
    );

    lpe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_DIVGO),
        .dividend (merge_res.wsum),
        .divisor  (merge_res.total),
        .quotient (quot),
        .stat     (div_stat)
    );

    // Lost when no lane is dark; otherwise clamp the centroid to the 13-bit range.
    always_comb begin
        lost = !merge_res.any_dark || (merge_res.total == '0);
        if (lost) begin
            pos = POSITION_LOST;
        end else if (quot > wsum_t'(POSITION_MAX)) begin
            pos = position_t'(POSITION_MAX);
        end else begin
            pos = position_t'(quot);
        end
    end

    // the output register can take a new result when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            was_lost_reg <= 1'b0;
            thr_reg      <= reading_t'(THRESHOLD_RESET);
            m_valid_reg  <= 1'b0;
            m_pos_reg    <= '0;
            m_lost_reg   <= 1'b0;
            m_recov_reg  <= 1'b0;
            for (int s = 0; s < SENSOR_COUNT; s++) begin
                m_mean_reg[s] <= '0;
            end
        end else begin
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end

            // raise valid on a new load, else drop the result once taken
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        // advance the ring slot with the write
                        slot_reg  <= (slot_reg == SLOT_W'(HISTORY_DEPTH - 1))
                                     ? '0 : slot_reg + SLOT_W'(1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:   state_reg <= ST_MEAN;
                ST_MEAN:  state_reg <= ST_MERGE;
                ST_MERGE: state_reg <= ST_DIVGO;
                ST_DIVGO: state_reg <= ST_DIV;
                ST_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold here until the output register is free
                    if (out_free) begin
                        m_pos_reg    <= pos;
                        m_lost_reg   <= lost;
                        m_recov_reg  <= !lost && was_lost_reg;
                        was_lost_reg <= lost;
                        for (int s = 0; s < SENSOR_COUNT; s++) begin
                            m_mean_reg[s] <= means[s];
                        end
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_mean_0         = m_mean_reg[0];
    assign m_mean_1         = m_mean_reg[1];
    assign m_mean_2         = m_mean_reg[2];
    assign m_mean_3         = m_mean_reg[3];
    assign m_mean_4         = m_mean_reg[4];
    assign m_line_position  = m_pos_reg;
    assign m_line_lost      = m_lost_reg;
    assign m_line_recovered = m_recov_reg;

    // no request may be taken while the divider is still working on the last one
    `LPE_ASSERT(a_no_accept_while_div, aclk, aresetn, !(s_ready && div_stat.busy), "request accepted while divider busy")
    // an accepted request closes the input until its result is out
    `LPE_ASSERT_NEXT(a_accept_closes_input, aclk, aresetn, s_valid && s_ready, !s_ready, "input still open after accept")
    // lost flag and lost position code agree on every shown result
    `LPE_ASSERT(a_lost_matches_pos, aclk, aresetn, !m_valid || (m_line_lost == (m_line_position == POSITION_LOST)), "lost flag disagrees with position")
    // a recovered edge never comes with a lost line
    `LPE_ASSERT(a_recovered_not_lost, aclk, aresetn, !m_valid || !(m_line_recovered && m_line_lost), "recovered while lost")

endmodule
